/* sv/tecb_pkg.sv */
package tecb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PAGE_SIZE    = 32;
  localparam int LINE_SIZE    = 16;

  localparam int ADDR_W   = $clog2(BUFFER_DEPTH);
  localparam int CURSOR_W = ADDR_W + 1;
  localparam int PAGE_W   = $clog2(BUFFER_DEPTH / PAGE_SIZE);
  localparam int OFFS_W   = $clog2(PAGE_SIZE);
  localparam int LINE_W   = $clog2(LINE_SIZE);
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic [CURSOR_W-1:0] CUR_DEPTH   = CURSOR_W'(BUFFER_DEPTH);
  localparam logic [CURSOR_W-1:0] CUR_RIGHT   = CURSOR_W'(BUFFER_DEPTH - 2);
  localparam logic [CURSOR_W-1:0] CUR_LINE    = CURSOR_W'(LINE_SIZE);
  localparam logic [CURSOR_W-1:0] CUR_LASTLN  = CURSOR_W'(BUFFER_DEPTH - LINE_SIZE);
  localparam logic [CURSOR_W-1:0] CUR_ONE     = CURSOR_W'(1);

  typedef enum logic [3:0] {
    REQ_WRITE      = 4'd0,
    REQ_WRITE_CASE = 4'd1,
    REQ_DELETE     = 4'd2,
    REQ_LEFT       = 4'd3,
    REQ_RIGHT      = 4'd4,
    REQ_UP         = 4'd5,
    REQ_DOWN       = 4'd6,
    REQ_ENTER      = 4'd7,
    REQ_PAGE       = 4'd8,
    REQ_CLEAR      = 4'd9,
    REQ_CAPS       = 4'd10,
    REQ_SERIAL     = 4'd11,
    REQ_READ       = 4'd12
  } req_e_t;

  typedef struct packed {
    logic acted;
    logic refresh;
    logic dclear;
    logic serial;
    logic is_read;
  } flags_t;

endpackage

/* sv/text_entry_cursor_buffer_top.sv */
// Text entry buffer: 256 characters in 8 pages of 32, cursor, page and caps state.
// Input channel in_*: one keyboard event per request. in_tuser carries the
// request type, in_tdata the character choices, page number and read index.
// Output channel out_*: exactly one result per request, carrying the acted flag,
// cursor, page, caps flag, redraw/clear/serial strobes and the read character.
// A request is captured on acceptance, executed in S_EXEC and its result loaded into
// the output register from S_DONE; a page clear first passes through S_SWEEP, which
// rewrites the page one entry per cycle through the single write port of the character
// memory. in_tready is low while a request is in flight, so no new request is taken until
// the last one's result is registered, and S_DONE waits while an untaken result is held.
// The result sits in an output register; a new request is accepted while it
// waits, but that request's result is held until the receiver takes the old one.
// Reset (rst_n low, synchronous) zeroes cursor, page, caps and the release
// filter, and marks every character as a space through per-entry valid bits,
// so the block is usable in the first cycle after reset.
module text_entry_cursor_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // char_plain[7:0], char_caps[15:8], page_select[18:16],
                                 // read_index[26:19], zero pad
  input  logic [3:0]  in_tuser,  // req_type[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // acted[0], cursor[9:1], page_now[12:10], caps_on[13],
                                 // refresh[14], display_clear[15], serial_request[16],
                                 // read_char[24:17], zero pad
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SWEEP, S_DONE} state_t;

  localparam int ADDR_W   = tecb_pkg::ADDR_W;
  localparam int CURSOR_W = tecb_pkg::CURSOR_W;
  localparam int PAGE_W   = tecb_pkg::PAGE_W;
  localparam int OFFS_W   = tecb_pkg::OFFS_W;
  localparam int LINE_W   = tecb_pkg::LINE_W;
  localparam int CHAR_W   = tecb_pkg::CHAR_W;

  state_t                   state_r, state_nxt;
  tecb_pkg::req_e_t         req_r;
  logic [CHAR_W-1:0]        plain_r, caps_ch_r;
  logic [PAGE_W-1:0]        psel_r;
  logic [ADDR_W-1:0]        ridx_r;

  logic [CURSOR_W-1:0]      cursor_r, cursor_nxt;
  logic [PAGE_W-1:0]        page_r, page_nxt;
  logic                     caps_r, caps_nxt;
  logic                     half_r, half_nxt;
  logic [OFFS_W-1:0]        sweep_r, sweep_nxt;
  tecb_pkg::flags_t         flags_r, flags_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              out_data_r, out_data_nxt;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_addr;
  logic [CHAR_W-1:0]        mem_wdata;
  logic [CHAR_W-1:0]        mem [tecb_pkg::BUFFER_DEPTH];
  logic [CHAR_W-1:0]        rd_data_r;
  logic [tecb_pkg::BUFFER_DEPTH-1:0] valid_r;
  logic                     rd_valid_r;

  logic                     follow;
  logic [CURSOR_W-1:0]      cur_dec;
  logic [CHAR_W-1:0]        rd_char;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cur_dec    = cursor_r - tecb_pkg::CUR_ONE;
  assign rd_char    = rd_valid_r ? rd_data_r : tecb_pkg::SPACE_CHAR;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    page_nxt      = page_r;
    caps_nxt      = caps_r;
    half_nxt      = half_r;
    sweep_nxt     = sweep_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = ridx_r;
    mem_wdata     = tecb_pkg::SPACE_CHAR;
    follow        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        flags_nxt = '0;
        state_nxt = S_DONE;
        if (req_r == tecb_pkg::REQ_READ) begin
          flags_nxt.acted   = 1'b1;
          flags_nxt.is_read = 1'b1;
        end else if (4'(req_r) > 4'(tecb_pkg::REQ_READ)) begin
          // undefined request code: no effect
        end else if (!half_r) begin
          half_nxt = 1'b1;  // first arrival of a key only arms the filter
        end else begin
          half_nxt        = 1'b0;
          flags_nxt.acted = 1'b1;
          unique case (req_r)
            tecb_pkg::REQ_WRITE, tecb_pkg::REQ_WRITE_CASE: begin
              flags_nxt.refresh = 1'b1;
              if (cursor_r < tecb_pkg::CUR_DEPTH) begin
                mem_we           = 1'b1;
                mem_addr         = cursor_r[ADDR_W-1:0];
                mem_wdata        = (req_r == tecb_pkg::REQ_WRITE_CASE && caps_r) ?
                                   caps_ch_r : plain_r;
                cursor_nxt       = cursor_r + tecb_pkg::CUR_ONE;
                flags_nxt.dclear = 1'b1;
                follow           = 1'b1;
              end
            end
            tecb_pkg::REQ_DELETE: begin
              flags_nxt.refresh = 1'b1;
              flags_nxt.dclear  = 1'b1;
              follow            = 1'b1;
              if (cursor_r != '0) begin
                cursor_nxt = cur_dec;
                if (cur_dec < tecb_pkg::CUR_DEPTH) begin
                  mem_we   = 1'b1;
                  mem_addr = cur_dec[ADDR_W-1:0];
                end
              end
            end
            tecb_pkg::REQ_LEFT: begin
              follow = 1'b1;
              if (cursor_r != '0) begin
                cursor_nxt        = cur_dec;
                flags_nxt.refresh = 1'b1;
              end
            end
            tecb_pkg::REQ_RIGHT: begin
              follow = 1'b1;
              if (cursor_r < tecb_pkg::CUR_RIGHT) begin
                cursor_nxt        = cursor_r + tecb_pkg::CUR_ONE;
                flags_nxt.refresh = 1'b1;
              end
            end
            tecb_pkg::REQ_UP: begin
              follow = 1'b1;
              if (cursor_r >= tecb_pkg::CUR_LINE) begin
                cursor_nxt        = cursor_r - tecb_pkg::CUR_LINE;
                flags_nxt.refresh = 1'b1;
              end
            end
            tecb_pkg::REQ_DOWN: begin
              follow = 1'b1;
              if (cursor_r < tecb_pkg::CUR_LASTLN) begin
                cursor_nxt        = cursor_r + tecb_pkg::CUR_LINE;
                flags_nxt.refresh = 1'b1;
              end
            end
            tecb_pkg::REQ_ENTER: begin
              flags_nxt.refresh = 1'b1;
              if (cursor_r < tecb_pkg::CUR_LASTLN) begin
                cursor_nxt = {cursor_r[CURSOR_W-1:LINE_W], LINE_W'(0)} + tecb_pkg::CUR_LINE;
                follow     = 1'b1;
              end
            end
            tecb_pkg::REQ_PAGE: begin
              // page count is a power of two filling the page field exactly
              flags_nxt.refresh = 1'b1;
              page_nxt          = psel_r;
              cursor_nxt        = CURSOR_W'({psel_r, OFFS_W'(0)});
            end
            tecb_pkg::REQ_CLEAR: begin
              flags_nxt.refresh = 1'b1;
              sweep_nxt         = '0;
              state_nxt         = S_SWEEP;
            end
            tecb_pkg::REQ_CAPS: begin
              caps_nxt = !caps_r;
            end
            default: begin
              flags_nxt.serial = 1'b1;
            end
          endcase
        end
      end

      S_SWEEP: begin
        // pages tile the store exactly, so every offset is inside it
        mem_we    = 1'b1;
        mem_addr  = {page_r, sweep_r};
        sweep_nxt = sweep_r + OFFS_W'(1);
        if (sweep_r == OFFS_W'(tecb_pkg::PAGE_SIZE - 1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'({flags_r.is_read ? rd_char : CHAR_W'(0),
                               flags_r.serial, flags_r.dclear, flags_r.refresh,
                               caps_r, page_r, cursor_r, flags_r.acted});
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (follow && cursor_nxt < tecb_pkg::CUR_DEPTH) begin
      page_nxt = cursor_nxt[ADDR_W-1:OFFS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      page_r      <= '0;
      caps_r      <= 1'b0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      page_r      <= page_nxt;
      caps_r      <= caps_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture and payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      req_r     <= tecb_pkg::req_e_t'(in_tuser);
      plain_r   <= in_tdata[7:0];
      caps_ch_r <= in_tdata[15:8];
      psel_r    <= in_tdata[18:16];
      ridx_r    <= in_tdata[26:19];
    end
    sweep_r    <= sweep_nxt;
    flags_r    <= flags_nxt;
    out_data_r <= out_data_nxt;
  end

  // character memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r  <= mem[mem_addr];
    rd_valid_r <= valid_r[mem_addr];
  end

  // entries never written since reset read as spaces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_addr] <= 1'b1;
    end
  end

endmodule
